// ===== sv/rri_pkg.sv =====
// shared types and defaults for the 2d ray intersection block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rri_pkg;

  localparam int COORD_BITS_DEF = 16;

  // per-request control carried beside the datapath
  typedef struct packed {
    logic valid;
    logic par;
    logic hit;
    logic negx;
    logic negy;
    logic ovfx;
    logic ovfy;
  } sb_t;

endpackage
`default_nettype wire

// ===== sv/rri_front.sv =====
// front end: differences, cross products, determinant, hit test, numerators
// depends on rri_pkg
`timescale 1ns / 1ps
`default_nettype none
module rri_front #(
  parameter int COORD_BITS = rri_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic signed [COORD_BITS-1:0]  ax,
  input  wire logic signed [COORD_BITS-1:0]  ay,
  input  wire logic signed [COORD_BITS-1:0]  atx,
  input  wire logic signed [COORD_BITS-1:0]  aty,
  input  wire logic signed [COORD_BITS-1:0]  bx,
  input  wire logic signed [COORD_BITS-1:0]  by,
  input  wire logic signed [COORD_BITS-1:0]  btx,
  input  wire logic signed [COORD_BITS-1:0]  bty,
  output rri_pkg::sb_t                       sb,
  output logic signed [COORD_BITS-1:0]       start_x,
  output logic signed [COORD_BITS-1:0]       start_y,
  output logic [4*COORD_BITS+3:0]            num_x,
  output logic [4*COORD_BITS+3:0]            num_y,
  output logic [2*COORD_BITS+2:0]            det_mag
);
  localparam int N  = COORD_BITS;
  localparam int D  = N + 1;
  localparam int P  = 2 * N + 2;
  localparam int S  = 2 * N + 3;
  localparam int NM = S + D;

  logic [3:0] vld;
  logic signed [N-1:0] sx1, sy1, sx2, sy2, sx3, sy3;
  logic signed [D-1:0] dax1, day1, dbx1, dby1, dx1, dy1;
  logic signed [D-1:0] dax2, day2;
  logic signed [P-1:0] pd1, pd2, pu1, pu2, pv1, pv2;
  logic signed [S-1:0] det_c, nu_c, nv_c;
  logic [D-1:0] daxm3, daym3;
  logic [S-1:0] num3, detm3;
  logic par3, hit3, negx3, negy3;
  logic par4, hit4, negx4, negy4;

  always_comb begin
    det_c = S'(pd1) - S'(pd2);
    nu_c  = S'(pu1) - S'(pu2);
    nv_c  = S'(pv1) - S'(pv2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dax1 <= D'(atx) - D'(ax);
      day1 <= D'(aty) - D'(ay);
      dbx1 <= D'(btx) - D'(bx);
      dby1 <= D'(bty) - D'(by);
      dx1  <= D'(bx) - D'(ax);
      dy1  <= D'(by) - D'(ay);
      sx1  <= ax;
      sy1  <= ay;

      pd1  <= P'(dbx1) * P'(day1);
      pd2  <= P'(dby1) * P'(dax1);
      pu1  <= P'(dy1) * P'(dbx1);
      pu2  <= P'(dx1) * P'(dby1);
      pv1  <= P'(dy1) * P'(dax1);
      pv2  <= P'(dx1) * P'(day1);
      dax2 <= dax1;
      day2 <= day1;
      sx2  <= sx1;
      sy2  <= sy1;

      par3  <= (det_c == '0);
      hit3  <= (det_c != '0) && (nu_c != '0) && (nv_c != '0)
               && (nu_c[S-1] == det_c[S-1]) && (nv_c[S-1] == det_c[S-1]);
      num3  <= nu_c[S-1] ? S'(-nu_c) : S'(nu_c);
      detm3 <= det_c[S-1] ? S'(-det_c) : S'(det_c);
      daxm3 <= dax2[D-1] ? D'(-dax2) : D'(dax2);
      daym3 <= day2[D-1] ? D'(-day2) : D'(day2);
      negx3 <= dax2[D-1];
      negy3 <= day2[D-1];
      sx3   <= sx2;
      sy3   <= sy2;

      num_x   <= NM'(num3) * NM'(daxm3);
      num_y   <= NM'(num3) * NM'(daym3);
      det_mag <= detm3;
      start_x <= sx3;
      start_y <= sy3;
      par4    <= par3;
      hit4    <= hit3;
      negx4   <= negx3;
      negy4   <= negy3;
    end
  end

  always_comb begin
    sb.valid = vld[3];
    sb.par   = par4;
    sb.hit   = hit4;
    sb.negx  = negx4;
    sb.negy  = negy4;
    sb.ovfx  = 1'b0;
    sb.ovfy  = 1'b0;
  end

endmodule
`default_nettype wire

// ===== sv/rri_div_cell.sv =====
// one restoring division cell: settles one quotient bit and passes on
// depends on rri_pkg for the default width
`timescale 1ns / 1ps
`default_nettype none
module rri_div_cell #(
  parameter int COORD_BITS = rri_pkg::COORD_BITS_DEF,
  parameter int SHIFT      = 0
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [4*COORD_BITS+3:0]     rem_in,
  input  wire logic [2*COORD_BITS+2:0]     det_in,
  input  wire logic [COORD_BITS:0]         q_in,
  output logic [4*COORD_BITS+3:0]          rem_out,
  output logic [2*COORD_BITS+2:0]          det_out,
  output logic [COORD_BITS:0]              q_out
);
  localparam int NM = 4 * COORD_BITS + 4;
  localparam int Q  = COORD_BITS + 1;

  logic [NM:0] trial;

  always_comb begin
    trial = {1'b0, rem_in} - ((NM + 1)'(det_in) << SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_out <= det_in;
      if (!trial[NM]) begin
        rem_out <= trial[NM-1:0];
        q_out   <= q_in | (Q'(1) << SHIFT);
      end else begin
        rem_out <= rem_in;
        q_out   <= q_in;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/ray_ray_intersection_2d.sv =====
// top level of the 2d ray intersection block: front end, division chain, output stage
// depends on rri_pkg, rri_front, rri_div_cell
`timescale 1ns / 1ps
`default_nettype none
// Takes one ray pair per cycle while not stalled and returns one result per request.
// The pipeline is four front-end stages (differences, products, sums and
// hit test, numerator products), one overflow check, a row of COORD_BITS + 1
// division cells that each settle one quotient bit for x and y, and the output
// register. The whole pipeline moves together, so a waiting result with m_tready
// low holds every stage and s_tready.
module ray_ray_intersection_2d #(
  parameter int COORD_BITS = rri_pkg::COORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // first_start_x, first_start_y, first_toward_x, first_toward_y,
  // second_start_x, second_start_y, second_toward_x, second_toward_y
  input  wire logic [8*COORD_BITS-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // hit_x, hit_y
  output logic [2*COORD_BITS-1:0]        m_tdata,
  // parallel_flag, hit_flag
  output logic [1:0]                     m_tuser
);
  localparam int N  = COORD_BITS;
  localparam int S  = 2 * N + 3;
  localparam int NM = 4 * N + 4;
  localparam int Q  = N + 1;
  localparam logic signed [N+2:0] P_MAX = $signed({3'b000, 1'b0, {(N-1){1'b1}}});
  localparam logic signed [N+2:0] P_MIN = $signed({3'b111, 1'b1, {(N-1){1'b0}}});

  logic en;
  rri_pkg::sb_t sb4;
  logic signed [N-1:0] sx4, sy4;
  logic [NM-1:0] numx4, numy4;
  logic [S-1:0] detm4;

  rri_pkg::sb_t        sbc [0:Q];
  logic signed [N-1:0] sxc [0:Q];
  logic signed [N-1:0] syc [0:Q];
  logic [NM-1:0]       remx [0:Q];
  logic [NM-1:0]       remy [0:Q];
  logic [S-1:0]        detx [0:Q];
  logic [S-1:0]        dety [0:Q];
  logic [Q-1:0]        qx [0:Q];
  logic [Q-1:0]        qy [0:Q];

  logic [NM-1:0] dlim;
  logic ovfx_c, ovfy_c;
  logic signed [N+2:0] px, py;
  logic signed [N-1:0] hx, hy;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  rri_front #(.COORD_BITS(N)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid && en),
    .ax(s_tdata[0*N +: N]), .ay(s_tdata[1*N +: N]),
    .atx(s_tdata[2*N +: N]), .aty(s_tdata[3*N +: N]),
    .bx(s_tdata[4*N +: N]), .by(s_tdata[5*N +: N]),
    .btx(s_tdata[6*N +: N]), .bty(s_tdata[7*N +: N]),
    .sb(sb4), .start_x(sx4), .start_y(sy4),
    .num_x(numx4), .num_y(numy4), .det_mag(detm4)
  );

  // quotient wider than Q bits always saturates
  always_comb begin
    dlim   = NM'(detm4) << Q;
    ovfx_c = (numx4 >= dlim);
    ovfy_c = (numy4 >= dlim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sbc[0].valid <= 1'b0;
    end else if (en) begin
      sbc[0] <= {sb4.valid, sb4.par, sb4.hit, sb4.negx, sb4.negy, ovfx_c, ovfy_c};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sxc[0]  <= sx4;
      syc[0]  <= sy4;
      remx[0] <= ovfx_c ? '0 : numx4;
      remy[0] <= ovfy_c ? '0 : numy4;
      detx[0] <= detm4;
      dety[0] <= detm4;
    end
  end

  assign qx[0] = '0;
  assign qy[0] = '0;

  for (genvar k = 0; k < Q; k++) begin : g_cell
    rri_div_cell #(.COORD_BITS(N), .SHIFT(Q - 1 - k)) u_cx (
      .clk(clk), .en(en), .rem_in(remx[k]), .det_in(detx[k]), .q_in(qx[k]),
      .rem_out(remx[k+1]), .det_out(detx[k+1]), .q_out(qx[k+1])
    );
    rri_div_cell #(.COORD_BITS(N), .SHIFT(Q - 1 - k)) u_cy (
      .clk(clk), .en(en), .rem_in(remy[k]), .det_in(dety[k]), .q_in(qy[k]),
      .rem_out(remy[k+1]), .det_out(dety[k+1]), .q_out(qy[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        sbc[k+1].valid <= 1'b0;
      end else if (en) begin
        sbc[k+1] <= sbc[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sxc[k+1] <= sxc[k];
        syc[k+1] <= syc[k];
      end
    end
  end

  always_comb begin
    px = sbc[Q].negx ? (N+3)'(sxc[Q]) - (N+3)'(qx[Q]) : (N+3)'(sxc[Q]) + (N+3)'(qx[Q]);
    py = sbc[Q].negy ? (N+3)'(syc[Q]) - (N+3)'(qy[Q]) : (N+3)'(syc[Q]) + (N+3)'(qy[Q]);

    if (sbc[Q].ovfx) begin
      hx = sbc[Q].negx ? {1'b1, {(N-1){1'b0}}} : {1'b0, {(N-1){1'b1}}};
    end else if (px > P_MAX) begin
      hx = {1'b0, {(N-1){1'b1}}};
    end else if (px < P_MIN) begin
      hx = {1'b1, {(N-1){1'b0}}};
    end else begin
      hx = px[N-1:0];
    end

    if (sbc[Q].ovfy) begin
      hy = sbc[Q].negy ? {1'b1, {(N-1){1'b0}}} : {1'b0, {(N-1){1'b1}}};
    end else if (py > P_MAX) begin
      hy = {1'b0, {(N-1){1'b1}}};
    end else if (py < P_MIN) begin
      hy = {1'b1, {(N-1){1'b0}}};
    end else begin
      hy = py[N-1:0];
    end

    if (!sbc[Q].hit) begin
      hx = '0;
      hy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= sbc[Q].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {hy, hx};
      m_tuser <= {sbc[Q].hit, sbc[Q].par};
    end
  end

endmodule
`default_nettype wire

// ===== sv/rri_checker.sv =====
// port-level checks for the 2d ray intersection block, with its bind
// depends on ray_ray_intersection_2d
`timescale 1ns / 1ps
`default_nettype none
module rri_checker #(
  parameter int COORD_BITS = rri_pkg::COORD_BITS_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    s_tready,
  input wire logic                    m_tvalid,
  input wire logic                    m_tready,
  input wire logic [2*COORD_BITS-1:0] m_tdata,
  input wire logic [1:0]              m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("parallel and hit both set");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata == '0)
    else $error("point not zero without hit");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

endmodule

bind ray_ray_intersection_2d rri_checker #(.COORD_BITS(COORD_BITS)) u_rri_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
